>>> rtl/pendulum_position_pid_drive_unit_assert.svh
// ----------------------------------------------------------------------------
// pendulum position pid drive assertion macros
// concurrent check wrappers sampled on clk, masked while rst_n is low
// ----------------------------------------------------------------------------
`ifndef PENDULUM_POSITION_PID_DRIVE_UNIT_ASSERT_SVH
`define PENDULUM_POSITION_PID_DRIVE_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define PPD_ASSERT_SAME(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("ppd check failed");

`define PPD_ASSERT_NEXT(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("ppd check failed");

`else

`define PPD_ASSERT_SAME(name, pre, post)

`define PPD_ASSERT_NEXT(name, pre, post)

`endif

`endif

>>> rtl/ppd_pkg.sv
// ----------------------------------------------------------------------------
// pendulum position pid drive package
// widths, reset values, register map and configuration type
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ppd_pkg;

    localparam int FAULT_BAND_DEF  = 800;
    localparam int GAIN_FRAC_DEF   = 8;

    localparam int POS_W   = 16;
    localparam int ANG_W   = 12;
    localparam int GAIN_W  = 16;
    localparam int DUTY_W  = 16;
    localparam int ERR_W   = 17;
    localparam int DIFF_W  = 18;
    localparam int SUM_W   = 32;
    localparam int RAW_W   = 50;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 5;

    localparam logic signed [GAIN_W-1:0] RST_GAIN_P  = 16'sd256;
    localparam logic signed [GAIN_W-1:0] RST_GAIN_I  = 16'sd0;
    localparam logic signed [GAIN_W-1:0] RST_GAIN_D  = 16'sd0;
    localparam logic signed [POS_W-1:0]  RST_TARGET  = 16'sd2000;
    localparam logic [DUTY_W-1:0]        RST_LIMIT   = 16'd7000;
    localparam logic [ANG_W-1:0]         RST_CENTER  = 12'd3050;
    localparam logic [ANG_W-1:0]         RST_ST_LOW  = 12'd2850;
    localparam logic [ANG_W-1:0]         RST_ST_HIGH = 12'd3250;

    typedef enum logic [2:0] {
        REG_GAIN_P      = 3'd0,
        REG_GAIN_I      = 3'd1,
        REG_GAIN_D      = 3'd2,
        REG_TARGET_POS  = 3'd3,
        REG_PWM_LIMIT   = 3'd4,
        REG_UPRIGHT_CTR = 3'd5,
        REG_START_LOW   = 3'd6,
        REG_START_HIGH  = 3'd7
    } ppd_reg_t;

    typedef struct packed {
        logic signed [GAIN_W-1:0] gain_p;
        logic signed [GAIN_W-1:0] gain_i;
        logic signed [GAIN_W-1:0] gain_d;
        logic signed [POS_W-1:0]  target_position;
        logic [DUTY_W-1:0]        pwm_limit;
        logic [ANG_W-1:0]         upright_center;
        logic [ANG_W-1:0]         start_low;
        logic [ANG_W-1:0]         start_high;
    } ppd_cfg_t;

endpackage

>>> rtl/ppd_if.sv
// ----------------------------------------------------------------------------
// pendulum position pid drive channels
// valid/ready channels for sensor ticks and drive commands
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ppd_in_if
    import ppd_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [POS_W-1:0] encoder_position;
    logic [ANG_W-1:0]        angle_reading;

    modport source (output valid, output encoder_position, output angle_reading,
                    input ready);
    modport sink   (input valid, input encoder_position, input angle_reading,
                    output ready);
endinterface

interface ppd_out_if
    import ppd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [DUTY_W-1:0] pwm_duty;
    logic              drive_reverse;
    logic              drive_enable;
    logic              start_flag;
    logic              fault;

    modport source (output valid, output pwm_duty, output drive_reverse,
                    output drive_enable, output start_flag, output fault,
                    input ready);
    modport sink   (input valid, input pwm_duty, input drive_reverse,
                    input drive_enable, input start_flag, input fault,
                    output ready);
endinterface

>>> rtl/ppd_apb_regs.sv
// ----------------------------------------------------------------------------
// pendulum position pid drive register file
// apb write and read access to the eight control registers
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ppd_apb_regs
    import ppd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output ppd_cfg_t          cfg
);

    ppd_cfg_t cfg_reg;
    ppd_cfg_t cfg_next;
    ppd_reg_t sel;
    logic     wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign sel    = ppd_reg_t'(paddr[ADDR_W-1:2]);
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (sel)
                REG_GAIN_P:      cfg_next.gain_p          = pwdata[GAIN_W-1:0];
                REG_GAIN_I:      cfg_next.gain_i          = pwdata[GAIN_W-1:0];
                REG_GAIN_D:      cfg_next.gain_d          = pwdata[GAIN_W-1:0];
                REG_TARGET_POS:  cfg_next.target_position = pwdata[POS_W-1:0];
                REG_PWM_LIMIT:   cfg_next.pwm_limit       = pwdata[DUTY_W-1:0];
                REG_UPRIGHT_CTR: cfg_next.upright_center  = pwdata[ANG_W-1:0];
                REG_START_LOW:   cfg_next.start_low       = pwdata[ANG_W-1:0];
                REG_START_HIGH:  cfg_next.start_high      = pwdata[ANG_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (sel)
            REG_GAIN_P:      prdata = DATA_W'(unsigned'(cfg_reg.gain_p));
            REG_GAIN_I:      prdata = DATA_W'(unsigned'(cfg_reg.gain_i));
            REG_GAIN_D:      prdata = DATA_W'(unsigned'(cfg_reg.gain_d));
            REG_TARGET_POS:  prdata = DATA_W'(unsigned'(cfg_reg.target_position));
            REG_PWM_LIMIT:   prdata = DATA_W'(cfg_reg.pwm_limit);
            REG_UPRIGHT_CTR: prdata = DATA_W'(cfg_reg.upright_center);
            REG_START_LOW:   prdata = DATA_W'(cfg_reg.start_low);
            REG_START_HIGH:  prdata = DATA_W'(cfg_reg.start_high);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_p          <= RST_GAIN_P;
            cfg_reg.gain_i          <= RST_GAIN_I;
            cfg_reg.gain_d          <= RST_GAIN_D;
            cfg_reg.target_position <= RST_TARGET;
            cfg_reg.pwm_limit       <= RST_LIMIT;
            cfg_reg.upright_center  <= RST_CENTER;
            cfg_reg.start_low       <= RST_ST_LOW;
            cfg_reg.start_high      <= RST_ST_HIGH;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> rtl/ppd_pid_pipe.sv
// ----------------------------------------------------------------------------
// pendulum position pid drive pipeline
// five register stages: capture, error and integral, products, sum, clamp
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "pendulum_position_pid_drive_unit_assert.svh"

module ppd_pid_pipe
    import ppd_pkg::*;
#(
    parameter int FAULT_BAND     = FAULT_BAND_DEF,
    parameter int GAIN_FRAC_BITS = GAIN_FRAC_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  ppd_cfg_t  cfg,
    ppd_in_if.sink    tick,
    ppd_out_if.source cmd
);

    localparam int PP_W  = GAIN_W + ERR_W;
    localparam int PI_W  = GAIN_W + SUM_W;
    localparam int PD_W  = GAIN_W + DIFF_W;
    localparam int BND_W = ANG_W + 2;

    localparam logic signed [BND_W-1:0] BAND = BND_W'(FAULT_BAND);

    // stall chain, each stage loads when it is empty or drains
    logic en0, en1, en2, en3, en4;
    logic v0_reg, v1_reg, v2_reg, v3_reg, v4_reg;

    // state
    logic signed [SUM_W-1:0]  error_sum_reg,  error_sum_next;
    logic signed [DIFF_W-1:0] last_error_reg;
    logic                     start_latched_reg, start_latched_next;

    // stage 0
    logic signed [POS_W-1:0] s0_pos_reg;
    logic [ANG_W-1:0]        s0_ang_reg;

    // stage 1
    logic signed [ERR_W-1:0]  err_next;
    logic signed [SUM_W:0]    sum_wide;
    logic signed [DIFF_W-1:0] diff_next;
    logic signed [BND_W-1:0]  ang_s, band_lo, band_hi;
    logic                     fault_next;
    logic signed [ERR_W-1:0]  s1_err_reg;
    logic signed [SUM_W-1:0]  s1_sum_reg;
    logic signed [DIFF_W-1:0] s1_diff_reg;
    logic                     s1_start_reg, s1_fault_reg;

    // stage 2
    logic signed [PP_W-1:0] s2_pp_reg;
    logic signed [PI_W-1:0] s2_pi_reg;
    logic signed [PD_W-1:0] s2_pd_reg;
    logic                   s2_start_reg, s2_fault_reg;

    // stage 3
    logic signed [RAW_W-1:0] s3_raw_reg;
    logic                    s3_start_reg, s3_fault_reg;

    // stage 4
    logic             neg;
    logic [RAW_W-1:0] mag_abs, mag;
    logic [DUTY_W-1:0] duty_next;
    logic [DUTY_W-1:0] duty_reg;
    logic              rev_reg, start_reg, fault_reg;

    assign en4 = !v4_reg || cmd.ready;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign en0 = !v0_reg || en1;

    assign tick.ready = en0;

    always_comb
    begin
        err_next  = ERR_W'(cfg.target_position) - ERR_W'(s0_pos_reg);
        sum_wide  = (SUM_W+1)'(error_sum_reg) + (SUM_W+1)'(err_next);
        // saturate the integral on overflow
        if (sum_wide[SUM_W] != sum_wide[SUM_W-1])
        begin
            error_sum_next = {sum_wide[SUM_W], {(SUM_W-1){~sum_wide[SUM_W]}}};
        end
        else
        begin
            error_sum_next = sum_wide[SUM_W-1:0];
        end
        diff_next = DIFF_W'(err_next) - last_error_reg;

        start_latched_next = start_latched_reg
                          || ((s0_ang_reg > cfg.start_low) && (s0_ang_reg < cfg.start_high));

        ang_s      = BND_W'(s0_ang_reg);
        band_lo    = BND_W'(cfg.upright_center) - BAND;
        band_hi    = BND_W'(cfg.upright_center) + BAND;
        fault_next = (ang_s < band_lo) || (ang_s > band_hi);
    end

    always_comb
    begin
        neg       = s3_raw_reg[RAW_W-1];
        mag_abs   = neg ? unsigned'(-s3_raw_reg) : unsigned'(s3_raw_reg);
        mag       = mag_abs >> GAIN_FRAC_BITS;
        duty_next = (mag > RAW_W'(cfg.pwm_limit)) ? cfg.pwm_limit : mag[DUTY_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg            <= 1'b0;
            v1_reg            <= 1'b0;
            v2_reg            <= 1'b0;
            v3_reg            <= 1'b0;
            v4_reg            <= 1'b0;
            error_sum_reg     <= '0;
            last_error_reg    <= '0;
            start_latched_reg <= 1'b0;
        end
        else
        begin
            if (en0)
            begin
                v0_reg <= tick.valid;
            end
            if (en1)
            begin
                v1_reg <= v0_reg;
                if (v0_reg)
                begin
                    error_sum_reg     <= error_sum_next;
                    last_error_reg    <= DIFF_W'(err_next);
                    start_latched_reg <= start_latched_next;
                end
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
            if (en4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en0)
        begin
            s0_pos_reg <= tick.encoder_position;
            s0_ang_reg <= tick.angle_reading;
        end
        if (en1)
        begin
            s1_err_reg   <= err_next;
            s1_sum_reg   <= error_sum_next;
            s1_diff_reg  <= diff_next;
            s1_start_reg <= start_latched_next;
            s1_fault_reg <= fault_next;
        end
        if (en2)
        begin
            s2_pp_reg    <= PP_W'(cfg.gain_p) * PP_W'(s1_err_reg);
            s2_pi_reg    <= PI_W'(cfg.gain_i) * PI_W'(s1_sum_reg);
            s2_pd_reg    <= PD_W'(cfg.gain_d) * PD_W'(s1_diff_reg);
            s2_start_reg <= s1_start_reg;
            s2_fault_reg <= s1_fault_reg;
        end
        if (en3)
        begin
            s3_raw_reg   <= RAW_W'(s2_pp_reg) + RAW_W'(s2_pi_reg) + RAW_W'(s2_pd_reg);
            s3_start_reg <= s2_start_reg;
            s3_fault_reg <= s2_fault_reg;
        end
        if (en4)
        begin
            duty_reg  <= duty_next;
            rev_reg   <= neg && (mag != '0);
            start_reg <= s3_start_reg;
            fault_reg <= s3_fault_reg;
        end
    end

    assign cmd.valid         = v4_reg;
    assign cmd.pwm_duty      = duty_reg;
    assign cmd.drive_reverse = rev_reg;
    assign cmd.drive_enable  = !fault_reg;
    assign cmd.start_flag    = start_reg;
    assign cmd.fault         = fault_reg;

    `PPD_ASSERT_SAME(a_duty_within_limit, v4_reg, duty_reg <= cfg.pwm_limit)
    `PPD_ASSERT_SAME(a_reverse_has_duty, v4_reg && rev_reg, duty_reg != '0 || cfg.pwm_limit == '0)
    `PPD_ASSERT_NEXT(a_integral_holds, !(en1 && v0_reg), $stable(error_sum_reg))
    `PPD_ASSERT_NEXT(a_start_sticky, start_latched_reg, start_latched_reg)

endmodule

>>> rtl/pendulum_position_pid_drive_unit.sv
// ----------------------------------------------------------------------------
// pendulum position pid drive unit
// pid cart controller with pwm clamp, start latch and angle fault
// ----------------------------------------------------------------------------
// Takes one sensor beat per clock cycle while the command side is ready, and
// returns one drive command beat per sensor beat, in order. Each sensor beat
// passes through the pipeline of capture, error and saturating integral, three
// gain multiplies (the widest 16 x 32 for the integral term), product sum, and
// the truncate and clamp stage. Back pressure on the command side stalls the
// pipeline from the output backwards. The user must write registers over the
// apb port only while no beat is in flight; the block does not enforce it.
`timescale 1ns / 1ps

module pendulum_position_pid_drive_unit
    import ppd_pkg::*;
#(
    parameter int FAULT_BAND     = FAULT_BAND_DEF,
    parameter int GAIN_FRAC_BITS = GAIN_FRAC_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    ppd_in_if.sink            tick,
    ppd_out_if.source         cmd
);

    ppd_cfg_t cfg;

    ppd_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ppd_pid_pipe #(
        .FAULT_BAND     (FAULT_BAND),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_pipe (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .tick  (tick),
        .cmd   (cmd)
    );

endmodule
